@@ hw/rtl/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sorter: controller states and the
// command / status groups between controller and datapath.
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [0:0] {
      ST_FILL  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;   // place the input value into the list
      logic shift;    // pop the list head toward the output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_one;  // exactly one entry left
      logic overflow;  // a value was dropped in this set
   } status_type;

endpackage

@@ hw/rtl/isort_datapath.sv @@
// ----------------------------------------------------------------------------
// isort_datapath
// Row of sorted cells with parallel compare-and-shift insertion, a fill
// count and the drop flag. Drains by shifting the row toward entry zero.
// ----------------------------------------------------------------------------
module isort_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  isort_pkg::cmd_type            cmd,
   input  logic signed [isort_pkg::DATA_W-1:0] value,
   output logic signed [isort_pkg::DATA_W-1:0] head,
   output isort_pkg::status_type         status
);
   import isort_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] store_in [DEPTH];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic [DEPTH-1:0]         lt;
   logic [DEPTH-1:0]         lt_prev;
   logic signed [DATA_W-1:0] val_prev [DEPTH];
   logic                     full;

   assign full = (count_ff == CW'(DEPTH));

   // each cell compares the new value with its own content
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CW'(i) < count_ff) && (value < store_ff[i]);
      end
      lt_prev[0]  = 1'b0;
      val_prev[0] = value;
      for (int i = 1; i < DEPTH; i++) begin
         lt_prev[i]  = lt[i-1];
         val_prev[i] = store_ff[i-1];
      end
   end

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.insert) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
            for (int i = 0; i < DEPTH; i++) begin
               // cells at or past the insertion point move up by one
               if (lt[i] || (CW'(i) == count_ff)) begin
                  store_in[i] = lt_prev[i] ? val_prev[i] : value;
               end
            end
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            store_in[i] = store_ff[i+1];
         end
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign head            = store_ff[0];
   assign status.last_one = (count_ff == CW'(1));
   assign status.overflow = ovf_ff;

endmodule

@@ hw/rtl/isort_ctrl.sv @@
// ----------------------------------------------------------------------------
// isort_ctrl
// Two-state controller: collect values until the last beat of a set, then
// drain the sorted list one beat per output handshake.
// ----------------------------------------------------------------------------
module isort_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  isort_pkg::status_type status,
   output isort_pkg::cmd_type    cmd
);
   import isort_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_FILL: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_tvalid = 1'b1;
            cmd.shift  = rsp_tready;
            // back to collecting once the final entry leaves
            if (rsp_tready && status.last_one) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

endmodule

@@ hw/rtl/insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable streaming sort of signed 32-bit values in sets of up to DEPTH.
// ----------------------------------------------------------------------------
// Each input beat is inserted into a row of DEPTH registers at the edge
// that accepts it: every cell compares the new value with its own content
// and the row opens a gap in parallel, so values arrive at one per cycle
// while filling. A value equal to stored ones lands after them. After the
// beat marked tlast is inserted the block stops taking input and drains the
// list, smallest first, one beat per output handshake, marks the final beat
// with rsp_tlast, and then empties the store. Values arriving while all
// DEPTH entries are taken are dropped, and rsp_tuser is high on every beat
// of that set.
// ----------------------------------------------------------------------------
module insertion_sorter #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value (signed)
   output logic        rsp_tlast,   // end_of_set
   output logic        rsp_tuser    // [0] dropped_any
);
   import isort_pkg::*;

   cmd_type                  cmd;
   status_type               status;
   logic signed [DATA_W-1:0] head;

   isort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   isort_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .value  ($signed(req_tdata)),
      .head   (head),
      .status (status)
   );

   assign rsp_tdata = head;
   assign rsp_tlast = status.last_one;
   assign rsp_tuser = status.overflow;

`ifndef SYNTHESIS
   // a set that ends always yields at least one result
   a_last_in_drains: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no output after last input beat");

   // the final result returns the block to accepting input
   a_last_out_refills: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block did not return to input after final result");

   // drop flag holds across all beats of one set
   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("drop flag changed within a set");
`endif

endmodule

@@ tb/tb_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// tb_insertion_sorter
// Self-checking testbench for the stable streaming insertion sorter.
// ----------------------------------------------------------------------------
// Sets of signed values go in on the req_ stream. Each accepted beat is put
// into a local sorted list. When a set closes, the list becomes the queue of
// expected rsp_ beats. A monitor compares every output beat field by field
// with the oldest expected beat. The tests cover directed extremes, a set
// that overflows the store with its closing beat dropped, a long output
// hold-off that stalls the input, and random sets with bursty traffic on
// both sides.
// ----------------------------------------------------------------------------
module tb_insertion_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import isort_pkg::*;

   localparam int SORT_DEPTH = 16;
   localparam int ITEM_BUDGET = 460;

   typedef enum int {TX_STEADY, TX_BURSTY} tx_mode_type;
   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;
   typedef enum int {
      VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_RISING, VAL_FALLING
   } val_style_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      bit                end_of_set;
      bit                dropped_any;
   } sort_beat_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;    // [31:0] value (signed)
   logic              req_tlast  = 1'b0;  // is_last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;          // [31:0] sorted_value (signed)
   logic              rsp_tlast;          // end_of_set
   logic              rsp_tuser;          // [0] dropped_any

   // local copy of the sorter state
   logic signed [DATA_W-1:0] held_values[$];
   bit                       overflow_pending;
   sort_beat_type            sorted_expect[$];

   tx_mode_type tx_mode = TX_STEADY;
   rx_mode_type rx_mode = RX_ALWAYS;
   int          burst_left;
   bit          tx_offering;
   int          stall_request;
   int          stall_left;
   int          rx_phase;

   int error_count;
   int items_sent;
   int sets_sent;
   int overflow_sets;
   int beats_checked;
   int holdoff_runs;

   insertion_sorter #(.DEPTH(SORT_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Insert one value the way the block does: after every stored value that
   // is less than or equal to it. On the closing beat emit the whole list.
   function automatic void predict_beat(logic signed [DATA_W-1:0] value, bit is_last);
      int            pos;
      sort_beat_type beat;
      if (held_values.size() >= SORT_DEPTH) begin
         overflow_pending = 1'b1;
      end else begin
         pos = held_values.size();
         while (pos > 0 && value < held_values[pos-1])
            pos--;
         held_values.insert(pos, value);
      end
      if (is_last) begin
         foreach (held_values[k]) begin
            beat.value       = held_values[k];
            beat.end_of_set  = (k == held_values.size() - 1);
            beat.dropped_any = overflow_pending;
            sorted_expect.push_back(beat);
         end
         if (overflow_pending)
            overflow_sets++;
         sets_sent++;
         held_values.delete();
         overflow_pending = 1'b0;
      end
   endfunction

   function automatic int next_gap();
      if (tx_mode == TX_STEADY)
         return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 7);
      return $urandom_range(1, 6);
   endfunction

   task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   // Call at a rising edge; returns after the beat is taken and any idle gap that follows.
   task automatic send_item(logic [DATA_W-1:0] value, bit is_last);
      int gap;
      req_tvalid  <= 1'b1;
      req_tdata   <= value;
      req_tlast   <= is_last;
      tx_offering = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_beat(value, is_last);
      items_sent++;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid  <= 1'b0;
         tx_offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Output side ready pattern, with an optional long hold-off.
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= (rx_phase % 5 >= 2);
            default:    rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
      rx_phase++;
   end

   always @(posedge clock) begin : check_results
      sort_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         beats_checked++;
         if (sorted_expect.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, '0);
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("sorted_value", rsp_tdata, want.value);
            if (rsp_tlast !== want.end_of_set)
               report_mismatch("end_of_set", DATA_W'(rsp_tlast),
                               DATA_W'(want.end_of_set));
            if (rsp_tuser !== want.dropped_any)
               report_mismatch("dropped_any", DATA_W'(rsp_tuser),
                               DATA_W'(want.dropped_any));
         end
      end
   end

   function automatic logic [DATA_W-1:0] pick_value(val_style_type style, int idx, int base);
      logic [DATA_W-1:0] corner[7];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                 32'h1, 32'h8000_0001, 32'h7FFF_FFFE};
      case (style)
         VAL_NARROW:  return $urandom_range(0, 8) - 4;
         VAL_EXTREME: return corner[$urandom_range(0, 6)];
         VAL_RISING:  return base + idx * $urandom_range(0, 3);
         VAL_FALLING: return base - idx * $urandom_range(0, 3);
         default:     return $urandom;
      endcase
   endfunction

   task automatic test_directed_extremes();
      logic [DATA_W-1:0] mix[8];
      mix = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
              32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      tx_mode = TX_STEADY;
      rx_mode = RX_ALWAYS;
      // a set of one value
      send_item(32'h7FFF_FFFF, 1'b1);
      // extremes of the range, with repeats
      foreach (mix[k])
         send_item(mix[k], k == 7);
   endtask

   task automatic test_overflow_drop();
      tx_mode = TX_BURSTY;
      rx_mode = RX_RANDOM;
      // falling values push every insert to the head; the closing beat is dropped
      for (int k = 0; k < SORT_DEPTH; k++)
         send_item(7 - k, 1'b0);
      send_item(32'd100, 1'b1);
   endtask

   task automatic test_receiver_holdoff();
      tx_mode = TX_STEADY;
      rx_mode = RX_ALWAYS;
      stall_request = 400;
      holdoff_runs++;
      for (int k = 0; k < SORT_DEPTH; k++)
         send_item($urandom, k == SORT_DEPTH - 1);
      // these are offered while the output is held, so the input stalls
      for (int k = 0; k < 6; k++)
         send_item($urandom, k == 5);
   endtask

   task automatic test_random_sets();
      int            set_len;
      int            pick;
      int            base;
      val_style_type style;
      while (items_sent < ITEM_BUDGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            set_len = $urandom_range(1, SORT_DEPTH);
         else if (pick < 17)
            set_len = SORT_DEPTH;
         else
            set_len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
         tx_mode = ($urandom_range(0, 3) == 0) ? TX_STEADY : TX_BURSTY;
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         style   = val_style_type'($urandom_range(0, 4));
         base    = $urandom;
         for (int k = 0; k < set_len; k++)
            send_item(pick_value(style, k, base), k == set_len - 1);
      end
   endtask

   task automatic finish_run();
      int waited;
      if (tx_offering) begin
         req_tvalid  <= 1'b0;
         tx_offering = 1'b0;
      end
      rx_mode = RX_ALWAYS;
      waited = 0;
      while (sorted_expect.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (sorted_expect.size() != 0) begin
         $display("[%0t] %0d expected beats never arrived", $time, sorted_expect.size());
         error_count += sorted_expect.size();
      end
      $display("Covered %0d input beats in %0d sets, %0d with dropped values.",
               items_sent, sets_sent, overflow_sets);
      $display("Checked %0d output beats across %0d long output hold-offs.",
               beats_checked, holdoff_runs);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_overflow_drop();
      test_receiver_holdoff();
      test_random_sets();
      finish_run();
   end

endmodule
